// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the gcd sequencer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EGCD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define EGCD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EGCD_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define EGCD_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// types and constants of the extended gcd block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package egcd_pkg;
    localparam int unsigned PORT_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic round_upd;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic y_zero;
    } status_t;
endpackage

// ===== sv/egcd_dp.sv =====
// ----------------------------------------------------------------------------
// egcd_dp
// euclid datapath: restoring divider with shift-add quotient products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module egcd_dp #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                               aclk,
    input  egcd_pkg::cmd_t                     cmd,
    output egcd_pkg::status_t                  status,
    input  logic        [egcd_pkg::PORT_W-1:0] first_operand,
    input  logic        [egcd_pkg::PORT_W-1:0] second_operand,
    output logic        [egcd_pkg::PORT_W-1:0] gcd_value,
    output logic signed [egcd_pkg::PORT_W-1:0] coef_first,
    output logic signed [egcd_pkg::PORT_W-1:0] coef_second
);
    logic [WIDTH-1:0] x_reg, y_reg, a_old_reg, a_cur_reg, b_old_reg, b_cur_reg;
    logic [WIDTH-1:0] rem_reg, dvd_reg, pa_reg, pb_reg;
    logic [WIDTH-1:0] gcd_reg, ca_reg, cb_reg;
    logic [WIDTH:0]   rem_shift, diff;
    logic             qbit;
    logic [WIDTH-1:0] rem_next, pa_next, pb_next;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, y_reg};
        qbit      = ~diff[WIDTH];
        rem_next  = qbit ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        pa_next   = {pa_reg[WIDTH-2:0], 1'b0} + (qbit ? a_cur_reg : '0);
        pb_next   = {pb_reg[WIDTH-2:0], 1'b0} + (qbit ? b_cur_reg : '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= first_operand[WIDTH-1:0];
            y_reg     <= second_operand[WIDTH-1:0];
            a_old_reg <= WIDTH'(1);
            a_cur_reg <= '0;
            b_old_reg <= '0;
            b_cur_reg <= WIDTH'(1);
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            dvd_reg <= x_reg;
            pa_reg  <= '0;
            pb_reg  <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
        end
        if (cmd.round_upd) begin
            x_reg     <= y_reg;
            y_reg     <= rem_reg;
            a_old_reg <= a_cur_reg;
            a_cur_reg <= a_old_reg - pa_reg;
            b_old_reg <= b_cur_reg;
            b_cur_reg <= b_old_reg - pb_reg;
        end
        if (cmd.capture) begin
            gcd_reg <= x_reg;
            ca_reg  <= a_old_reg;
            cb_reg  <= b_old_reg;
        end
    end

    assign status.y_zero = (y_reg == '0);
    assign gcd_value   = egcd_pkg::PORT_W'(gcd_reg);
    assign coef_first  = egcd_pkg::PORT_W'(signed'(ca_reg));
    assign coef_second = egcd_pkg::PORT_W'(signed'(cb_reg));
endmodule

// ===== sv/egcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// egcd_ctrl
// sequencer for euclid rounds and the result handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module egcd_ctrl #(
    parameter int unsigned WIDTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output egcd_pkg::cmd_t    cmd,
    input  egcd_pkg::status_t status
);
    localparam int unsigned CNT_W = $clog2(WIDTH);

    egcd_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= egcd_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            egcd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = egcd_pkg::ST_CHECK;
                end
            end
            egcd_pkg::ST_CHECK: begin
                if (status.y_zero) begin
                    state_next = egcd_pkg::ST_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = egcd_pkg::ST_DIV;
                end
            end
            egcd_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = egcd_pkg::ST_UPD;
                end
            end
            egcd_pkg::ST_UPD: begin
                cmd.round_upd = 1'b1;
                state_next    = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.capture  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = egcd_pkg::ST_IDLE;
                end
            end
            default: state_next = egcd_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

    `EGCD_ASSERT_IMP(a_capture_free, aclk, aresetn, cmd.capture, !m_valid_reg || m_ready, "result overwritten")
    `EGCD_ASSERT_NXT(a_valid_holds, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg, "result dropped")
    `EGCD_ASSERT_NXT(a_div_end, aclk, aresetn, state_reg == egcd_pkg::ST_DIV && cnt_last, state_reg == egcd_pkg::ST_UPD, "divide overrun")
endmodule

// ===== sv/extended_gcd_bezout.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// extended euclid: gcd and bezout coefficients of two unsigned operands
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_       in         first_operand, second_operand
// m_       out        gcd_value, coef_first, coef_second
//
// each round checks y, divides one quotient bit per cycle, then updates the coefficients
// one request at a time; a new one is taken while the last result waits
// aresetn clears the sequencer and the result valid
`timescale 1ns / 1ps
module extended_gcd_bezout #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [egcd_pkg::PORT_W-1:0] s_first_operand,
    input  logic        [egcd_pkg::PORT_W-1:0] s_second_operand,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [egcd_pkg::PORT_W-1:0] m_gcd_value,
    output logic signed [egcd_pkg::PORT_W-1:0] m_coef_first,
    output logic signed [egcd_pkg::PORT_W-1:0] m_coef_second
);
    egcd_pkg::cmd_t    cmd;
    egcd_pkg::status_t status;

    egcd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    egcd_dp #(.WIDTH(WIDTH)) u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .first_operand  (s_first_operand),
        .second_operand (s_second_operand),
        .gcd_value      (m_gcd_value),
        .coef_first     (m_coef_first),
        .coef_second    (m_coef_second)
    );
endmodule

// ===== tb/extended_gcd_bezout_tb.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout_tb
// drives operand pairs into the extended gcd block and checks every gcd and
// bezout coefficient pair against an in-bench euclid computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module extended_gcd_bezout_tb;
    localparam int unsigned W = egcd_pkg::PORT_W;
    localparam int unsigned IDLE_LIMIT = 200000;

    typedef struct {
        logic [W-1:0] x;
        logic [W-1:0] y;
    } operands_t;

    typedef struct {
        logic [W-1:0] g;
        logic [W-1:0] ca;
        logic [W-1:0] cb;
    } bezout_t;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    logic [W-1:0] s_first_operand;
    logic [W-1:0] s_second_operand;
    logic         m_valid;
    logic         m_ready;
    logic [W-1:0] m_gcd_value;
    logic [W-1:0] m_coef_first;
    logic [W-1:0] m_coef_second;

    operands_t pending_reqs[$];
    bezout_t   expected_bezout[$];
    int        n_mismatch;
    int        quiet_cycles;
    int        send_wait;
    int        recv_wait;
    int        recv_draw;
    int        hold_off;
    bit        stim_done;
    bit        drain_req;
    bit        in_fire;
    bit        out_fire;

    extended_gcd_bezout #(.WIDTH(W)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_first_operand(s_first_operand), .s_second_operand(s_second_operand),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_gcd_value(m_gcd_value), .m_coef_first(m_coef_first),
        .m_coef_second(m_coef_second)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bezout_t euclid_bezout(operands_t op);
        bezout_t      r;
        logic [W-1:0] x, y, q, rem, t;
        logic [W-1:0] a0, a1, b0, b1;
        x = op.x;
        y = op.y;
        a0 = 1;
        a1 = 0;
        b0 = 0;
        b1 = 1;
        while (y != 0) begin
            q = x / y;
            rem = x % y;
            x = y;
            y = rem;
            t = a1;
            a1 = a0 - q * a1;
            a0 = t;
            t = b1;
            b1 = b0 - q * b1;
            b0 = t;
        end
        r.g = x;
        r.ca = a0;
        r.cb = b0;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, W - 1);
            1: v = v & 64'hFF;
            2: v = v >> $urandom_range(W - 16, W - 1);
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_req(logic [W-1:0] x, logic [W-1:0] y);
        operands_t op;
        op.x = x;
        op.y = y;
        pending_reqs.push_back(op);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_fire) begin
        end else if (send_wait > 0) begin
            s_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (drain_req && expected_bezout.size() != 0) begin
            s_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            s_valid <= 1'b1;
            s_first_operand <= pending_reqs[0].x;
            s_second_operand <= pending_reqs[0].y;
            expected_bezout.push_back(euclid_bezout(pending_reqs[0]));
            void'(pending_reqs.pop_front());
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            drain_req <= 1'b0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (out_fire) begin
            recv_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            m_ready <= (recv_draw == 0);
            recv_wait <= recv_draw;
        end else if (recv_wait > 0) begin
            m_ready <= 1'b0;
            recv_wait <= recv_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_bezout.size() == 0) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("unexpected result gcd=%h", m_gcd_value);
                end else begin
                    if (m_gcd_value !== expected_bezout[0].g
                            || m_coef_first !== expected_bezout[0].ca
                            || m_coef_second !== expected_bezout[0].cb) begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10)
                            $display("mismatch exp %h %h %h got %h %h %h",
                                expected_bezout[0].g, expected_bezout[0].ca,
                                expected_bezout[0].cb, m_gcd_value,
                                m_coef_first, m_coef_second);
                    end
                    void'(expected_bezout.pop_front());
                end
            end
        end
    end

    initial begin
        logic [W-1:0] g;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_first_operand = '0;
        s_second_operand = '0;
        n_mismatch = 0;
        quiet_cycles = 0;
        send_wait = 0;
        recv_wait = 0;
        recv_draw = 0;
        hold_off = 0;
        stim_done = 1'b0;
        drain_req = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;

        // directed: zeros, extremes, fibonacci pair, equal operands
        add_req(0, 0);
        add_req(64'h1234, 0);
        add_req(0, 64'h1234);
        add_req('1, 0);
        add_req(0, '1);
        add_req('1, '1);
        add_req('1, 1);
        add_req(1, '1);
        add_req('1, '1 - 1);
        add_req(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        add_req(64'h8000_0000_0000_0000, 3);
        add_req(64'hA94F_AD42_221F_2702, 64'h68A3_DD8E_61EC_CFBD);
        add_req(64'h68A3_DD8E_61EC_CFBD, 64'hA94F_AD42_221F_2702);
        add_req(240, 46);
        add_req(17, 17);
        add_req(1, 1);
        add_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        add_req(7, 64'hFFFF_FFFF_FFFF_FFC5);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 1300; i++) begin
            if (i == 300) begin
                wait (pending_reqs.size() == 0);
                drain_req = 1'b1;
            end
            if (i == 600) begin
                wait (pending_reqs.size() == 0);
                hold_off = 3000;
            end
            if ($urandom_range(0, 4) == 0) begin
                g = rand_word() >> $urandom_range(32, 60);
                add_req(g * (rand_word() >> 34), g * (rand_word() >> 34));
            end else begin
                add_req(rand_word(), rand_word());
            end
            if (pending_reqs.size() > 8)
                wait (pending_reqs.size() <= 2);
        end
        wait (pending_reqs.size() == 0);
        stim_done = 1'b1;
    end

    initial begin
        wait (aresetn);
        while (!(stim_done && expected_bezout.size() == 0 && !s_valid)
                && quiet_cycles < IDLE_LIMIT)
            @(posedge aclk);
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("extended_gcd_bezout_tb: done, errors");
        end else begin
            repeat (50) @(posedge aclk);
            if (n_mismatch == 0 && expected_bezout.size() == 0)
                $display("extended_gcd_bezout_tb: done, clean");
            else
                $display("extended_gcd_bezout_tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/egcd_pkg.sv
sv/egcd_dp.sv
sv/egcd_ctrl.sv
sv/extended_gcd_bezout.sv
tb/extended_gcd_bezout_tb.sv
